### rtl/rbcf_pkg.sv
// Shared types, codes and constants for the receive buffer with congestion feedback.
`default_nettype none

package rbcf_pkg;

	// Widths fixed by the item formats.
	localparam int REQ_W  = 2;
	localparam int PKT_W  = 32;
	localparam int KIND_W = 2;
	localparam int PCT_W  = 7;
	localparam int CFG_W  = 7;
	localparam int IDX_W  = 1;

	// Default sizing.
	localparam int MAX_DEPTH_DEF   = 64;
	localparam int DATA_WIDTH_DEF  = 32;
	localparam int CMD_Q_DEPTH_DEF = 2;

	// Percentage scale.
	localparam int PCT_SCALE = 100;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_DATA     = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FEEDBACK = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SERVICE  = 2'd2;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_DELIVER  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FEEDBACK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DROP     = 2'd2;

	// Register indexes and reset values.
	localparam logic [IDX_W-1:0] REG_BUFFER_CAPACITY = 1'd0;
	localparam logic [IDX_W-1:0] REG_THRESHOLD_PCT   = 1'd1;
	localparam logic [CFG_W-1:0] CAPACITY_RESET      = 7'd64;
	localparam logic [CFG_W-1:0] THRESHOLD_RESET     = 7'd20;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [PKT_W-1:0] packet_data;
	} req_t;

	typedef struct packed {
		logic [KIND_W-1:0] result_kind;
		logic [PKT_W-1:0]  packet_out;
		logic [PCT_W-1:0]  remaining_pct;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_DATA,
		OP_FEEDBACK,
		OP_SERVICE
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t          op;
		logic [PKT_W-1:0] packet_data;
	} cmd_t;

	typedef struct packed {
		logic [CFG_W-1:0] capacity;
		logic [CFG_W-1:0] threshold;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/rbcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rbcf_ram #(
	parameter int WIDTH = rbcf_pkg::DATA_WIDTH_DEF,
	parameter int DEPTH = rbcf_pkg::MAX_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/rbcf_front.sv
// Front end: accepts request transfers, classifies them and drops unused codes.
`default_nettype none

module rbcf_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire rbcf_pkg::req_t req,
	input  wire logic           req_valid,
	output logic                req_ready,
	output rbcf_pkg::cmd_t      cmd,
	output logic                cmd_valid,
	input  wire logic           cmd_ready
);

	rbcf_pkg::cmd_t  cmd_s1;
	logic            valid_s1;
	rbcf_pkg::cmd_op_t op;
	logic            keep;

	// Map the request code to an internal command; the unused code is discarded here.
	always_comb begin
		op   = rbcf_pkg::OP_DATA;
		keep = 1'b1;
		case (req.req_type)
			rbcf_pkg::REQ_DATA:     op = rbcf_pkg::OP_DATA;
			rbcf_pkg::REQ_FEEDBACK: op = rbcf_pkg::OP_FEEDBACK;
			rbcf_pkg::REQ_SERVICE:  op = rbcf_pkg::OP_SERVICE;
			default:                keep = 1'b0;
		endcase
	end

	assign req_ready = !valid_s1 || cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			cmd_s1.op          <= op;
			cmd_s1.packet_data <= req.packet_data;
		end
	end

	assign cmd       = cmd_s1;
	assign cmd_valid = valid_s1;

endmodule

`default_nettype wire

### rtl/rbcf_cmd_q.sv
// Short command queue between the front end and the back end.
`default_nettype none

module rbcf_cmd_q #(
	parameter int DEPTH = rbcf_pkg::CMD_Q_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire rbcf_pkg::cmd_t push,
	input  wire logic           push_valid,
	output logic                push_ready,
	output rbcf_pkg::cmd_t      pop,
	output logic                pop_valid,
	input  wire logic           pop_ready
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	rbcf_pkg::cmd_t entry_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop        = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push;
		end
	end

endmodule

`default_nettype wire

### rtl/rbcf_back.sv
// Back end: packet store, occupancy tracking, percentage divider and result register.
`default_nettype none

module rbcf_back #(
	parameter int MAX_DEPTH  = rbcf_pkg::MAX_DEPTH_DEF,
	parameter int DATA_WIDTH = rbcf_pkg::DATA_WIDTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire rbcf_pkg::cfg_t cfg,
	input  wire rbcf_pkg::cmd_t cmd,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	output rbcf_pkg::rsp_t      rsp,
	output logic                rsp_valid,
	input  wire logic           rsp_ready
);

	localparam int AW     = $clog2(MAX_DEPTH);
	localparam int OW     = $clog2(MAX_DEPTH + 1);
	localparam int CW     = rbcf_pkg::CFG_W;
	localparam int XW     = (OW > CW) ? OW : CW;
	localparam int PW     = rbcf_pkg::PCT_W;
	localparam int PROD_W = CW + PW;
	localparam int SW     = $clog2(PW);
	localparam int KW     = rbcf_pkg::PKT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DECIDE,
		ST_READ
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  head_q;
	logic [AW-1:0]  tail_q;
	logic [OW-1:0]  occ_q;
	logic           slow_q;
	logic           fb_sent_q;
	logic [CW-1:0]  rem_q;
	logic [PW-1:0]  nlo_q;
	logic [PW-1:0]  quo_q;
	logic [SW-1:0]  step_q;
	rbcf_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;

	logic [XW-1:0]         cfg_cap_x;
	logic [XW-1:0]         depth_x;
	logic [XW-1:0]         cap_x;
	logic [XW-1:0]         occ_x;
	logic [CW-1:0]         cap;
	logic                  full;
	logic                  empty;
	logic [CW-1:0]         free;
	logic [PROD_W-1:0]     prod;
	logic [CW:0]           trial;
	logic [CW:0]           diff;
	logic                  ge;
	logic                  send_fb;
	logic                  slot_free;
	logic                  cmd_fire;
	logic                  rsp_load;
	logic [AW-1:0]         head_nxt;
	logic [AW-1:0]         tail_nxt;
	logic                  ram_we;
	logic                  ram_re;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic [DATA_WIDTH-1:0] ram_rdata;
	logic [KW-1:0]         cmd_pkt;
	logic [KW-1:0]         rd_pkt;

	// Effective capacity: zero acts as one, anything above the store depth is clamped.
	assign cfg_cap_x = XW'(cfg.capacity);
	assign depth_x   = XW'(MAX_DEPTH);
	assign cap_x     = (cfg_cap_x == '0) ? XW'(1) :
	                   (cfg_cap_x > depth_x) ? depth_x : cfg_cap_x;
	assign cap       = cap_x[CW-1:0];
	assign occ_x     = XW'(occ_q);
	assign full      = occ_x >= cap_x;
	assign empty     = occ_q == '0;
	assign free      = full ? '0 : CW'(cap_x - occ_x);
	assign prod      = PROD_W'(free) * PROD_W'(rbcf_pkg::PCT_SCALE);

	// One restoring division step per cycle; the remainder always stays below the capacity.
	assign trial = {rem_q, nlo_q[PW-1]};
	assign ge    = trial >= {1'b0, cap};
	assign diff  = trial - {1'b0, cap};

	assign send_fb   = ((quo_q < cfg.threshold) || slow_q) && !fb_sent_q;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign cmd_ready = (state_q == ST_IDLE) && slot_free;
	assign cmd_fire  = cmd_valid && cmd_ready;

	// A new result is loaded on a drop, on a feedback decision and on every store read.
	assign rsp_load = ((state_q == ST_IDLE) && cmd_fire && (cmd.op == rbcf_pkg::OP_DATA) &&
	                   full) ||
	                  ((state_q == ST_DECIDE) && send_fb) ||
	                  (state_q == ST_READ);

	assign head_nxt = (head_q == AW'(MAX_DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign tail_nxt = (tail_q == AW'(MAX_DEPTH - 1)) ? '0 : tail_q + AW'(1);

	// Tokens are kept at the store width and shown at the port width.
	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_wdata
		if (i < KW) begin : g_bit
			assign ram_wdata[i] = cmd.packet_data[i];
		end else begin : g_zero
			assign ram_wdata[i] = 1'b0;
		end
	end

	for (genvar i = 0; i < KW; i++) begin : g_pkt
		if (i < DATA_WIDTH) begin : g_bit
			assign cmd_pkt[i] = cmd.packet_data[i];
			assign rd_pkt[i]  = ram_rdata[i];
		end else begin : g_zero
			assign cmd_pkt[i] = 1'b0;
			assign rd_pkt[i]  = 1'b0;
		end
	end

	assign ram_we = (state_q == ST_IDLE) && cmd_fire && (cmd.op == rbcf_pkg::OP_DATA) && !full;
	assign ram_re = ((state_q == ST_IDLE) && cmd_fire && (cmd.op == rbcf_pkg::OP_SERVICE) &&
	                 !empty && fb_sent_q) ||
	                ((state_q == ST_DECIDE) && !send_fb);

	rbcf_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MAX_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			slow_q      <= 1'b0;
			fb_sent_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						case (cmd.op)
							rbcf_pkg::OP_DATA: begin
								if (full) begin
									rsp_q.result_kind   <= rbcf_pkg::KIND_DROP;
									rsp_q.packet_out    <= cmd_pkt;
									rsp_q.remaining_pct <= '0;
								end else begin
									tail_q <= tail_nxt;
									occ_q  <= occ_q + OW'(1);
								end
							end
							rbcf_pkg::OP_FEEDBACK: begin
								slow_q <= 1'b1;
							end
							rbcf_pkg::OP_SERVICE: begin
								if (!empty) begin
									if (fb_sent_q) begin
										state_q <= ST_READ;
									end else begin
										rem_q   <= prod[PROD_W-1:PW];
										nlo_q   <= prod[PW-1:0];
										quo_q   <= '0;
										step_q  <= '0;
										state_q <= ST_DIV;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIV: begin
					rem_q  <= ge ? diff[CW-1:0] : trial[CW-1:0];
					nlo_q  <= {nlo_q[PW-2:0], 1'b0};
					quo_q  <= {quo_q[PW-2:0], ge};
					step_q <= step_q + SW'(1);
					if (step_q == SW'(PW - 1)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (send_fb) begin
						fb_sent_q           <= 1'b1;
						rsp_q.result_kind   <= rbcf_pkg::KIND_FEEDBACK;
						rsp_q.packet_out    <= '0;
						rsp_q.remaining_pct <= quo_q;
						state_q             <= ST_IDLE;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					head_q              <= head_nxt;
					occ_q               <= occ_q - OW'(1);
					slow_q              <= 1'b0;
					fb_sent_q           <= 1'b0;
					rsp_q.result_kind   <= rbcf_pkg::KIND_DELIVER;
					rsp_q.packet_out    <= rd_pkt;
					rsp_q.remaining_pct <= '0;
					state_q             <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

### rtl/rx_buffer_with_congestion_feedback_core.sv
// Top level of the receive buffer with tail drop and congestion feedback.
`default_nettype none

// This block queues incoming packet tokens in a circular store of MAX_DEPTH entries and
// drops a data arrival, returning a drop result that carries its token, when the queue
// already holds buffer_capacity packets (zero acts as one, values above MAX_DEPTH act as
// MAX_DEPTH). A feedback arrival from downstream sets a slow flag and gives no result. A
// service slot on a non-empty queue either emits one feedback result carrying the floor
// percent of free capacity, when that percent is below threshold_pct or the slow flag is
// set and no feedback is outstanding, or else delivers the head packet and clears both
// flags; a service slot on an empty queue and the unused request code give no result.
// Each request transfer first passes a registered front stage and a two-entry command
// queue, so requests keep being taken while the back end works or a result waits. The
// back end handles one command at a time: a data or feedback arrival and a service slot
// on an empty queue are done in the state that takes the command, a delivery right after
// a feedback goes from that state to a store read state, and any other service slot runs
// through a seven-step restoring divider that yields one quotient bit per cycle, then a
// decision state and, for a delivery, a store read state.
// A new command is started only once the result register is free or being taken. The
// two configuration registers may be written only while no request is in flight.

module rx_buffer_with_congestion_feedback_core #(
	parameter int MAX_DEPTH   = rbcf_pkg::MAX_DEPTH_DEF,
	parameter int DATA_WIDTH  = rbcf_pkg::DATA_WIDTH_DEF,
	parameter int CMD_Q_DEPTH = rbcf_pkg::CMD_Q_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire rbcf_pkg::req_t                 req,
	input  wire logic                           req_valid,
	output logic                                req_ready,
	output rbcf_pkg::rsp_t                      rsp,
	output logic                                rsp_valid,
	input  wire logic                           rsp_ready,
	input  wire logic                           cfg_we,
	input  wire logic [rbcf_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [rbcf_pkg::CFG_W-1:0]     cfg_data
);

	rbcf_pkg::cfg_t cfg_q;
	rbcf_pkg::cmd_t front_cmd;
	logic           front_valid;
	logic           front_ready;
	rbcf_pkg::cmd_t back_cmd;
	logic           back_valid;
	logic           back_ready;

	// Configuration registers. Writes take effect at once and are never read back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity  <= rbcf_pkg::CAPACITY_RESET;
			cfg_q.threshold <= rbcf_pkg::THRESHOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rbcf_pkg::REG_BUFFER_CAPACITY: cfg_q.capacity  <= cfg_data;
				rbcf_pkg::REG_THRESHOLD_PCT:   cfg_q.threshold <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The front stage classifies each request and discards the unused code.
	rbcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	// The command queue lets the front keep taking transfers while the back end divides.
	rbcf_cmd_q #(
		.DEPTH (CMD_Q_DEPTH)
	) u_cmd_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_cmd),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop        (back_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	// The back end owns the packet store, the flags and the result register.
	rbcf_back #(
		.MAX_DEPTH  (MAX_DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (back_cmd),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

endmodule

`default_nettype wire
